>>> design/amcf_pkg.sv
// ----------------------------------------------------------------------------
// AVI movi chunk framer package
// Shared codes, widths, the request record between the two pipeline halves
// and the chunk tag builder.
// ----------------------------------------------------------------------------
package amcf_pkg;

  localparam int unsigned MAX_STREAMS = 100;

  // Input command codes (carried on in_tuser).
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Result kind codes (carried on out_tuser).
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_INDEX = 1'b1;

  localparam logic [4:0] KEY_FLAG = 5'h10;

  localparam logic [1:0] FTYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] FTYPE_INTRA   = 2'd1;

  localparam logic [7:0] CHR_0 = 8'h30;
  localparam logic [7:0] CHR_D = 8'h64;
  localparam logic [7:0] CHR_C = 8'h63;
  localparam logic [7:0] CHR_W = 8'h77;
  localparam logic [7:0] CHR_B = 8'h62;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 104;

  // Chunk header is eight bytes; results per frame start are the index entry
  // plus the header.
  localparam int unsigned HDR_BYTES = 8;
  localparam logic [3:0]  LAST_HDR_CNT = 4'(HDR_BYTES);

  // One request handed from the frame logic to the result sequencer.
  typedef struct packed {
    logic        is_frame;   // index entry plus chunk header
    logic        pad;        // payload byte followed by a zero pad byte
    logic [31:0] tag;
    logic [4:0]  flags;
    logic [31:0] position;
    logic [23:0] length;
    logic [7:0]  data;
  } amcf_req_t;

  // Builds the four tag characters, first character in the low byte.
  // The tens digit uses a reciprocal multiply, exact for every 7-bit stream number.
  function automatic logic [31:0] make_tag(input logic [6:0] stream,
                                           input logic       video);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      prod = 15'(stream) * 15'd205;
      tens = prod[14:11];
      ones = stream - 7'(tens) * 7'd10;
      make_tag = {video ? CHR_C : CHR_B,
                  video ? CHR_D : CHR_W,
                  CHR_0 + 8'(ones),
                  CHR_0 + 8'(tens)};
    end
  endfunction

endpackage

>>> design/amcf_core.sv
// ----------------------------------------------------------------------------
// AVI movi chunk framer: input register and frame state
// Holds one input item, updates the offset and frame state when the item
// moves on, and issues a result request for items that produce output.
// ----------------------------------------------------------------------------
module amcf_core #(
  parameter int unsigned MAX_STREAMS = amcf_pkg::MAX_STREAMS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_cmd,
  input  logic [6:0]           in_stream,
  input  logic                 in_video,
  input  logic [1:0]           in_ftype,
  input  logic [23:0]          in_len,
  input  logic [31:0]          in_dur,
  input  logic [7:0]           in_data,
  output logic                 req_valid,
  input  logic                 req_ready,
  output amcf_pkg::amcf_req_t  req
);

  logic        item_valid_r;
  logic        cmd_r;
  logic [6:0]  stream_r;
  logic        video_r;
  logic [1:0]  ftype_r;
  logic [23:0] len_r;
  logic        dur_neg_r;
  logic [7:0]  data_r;

  logic [31:0] movi_offset_r, movi_offset_nxt;
  logic [23:0] bytes_left_r,  bytes_left_nxt;
  logic        odd_r,         odd_nxt;
  logic        dropping_r,    dropping_nxt;

  logic        has_result;
  logic        consume;
  logic [23:0] left_dec;

  assign left_dec = bytes_left_r - 24'd1;

  always_comb begin
    movi_offset_nxt = movi_offset_r;
    bytes_left_nxt  = bytes_left_r;
    odd_nxt         = odd_r;
    dropping_nxt    = dropping_r;
    has_result      = 1'b0;
    req.is_frame    = 1'b0;
    req.pad         = 1'b0;
    req.tag         = amcf_pkg::make_tag(stream_r, video_r);
    req.flags       = (ftype_r == amcf_pkg::FTYPE_UNKNOWN ||
                       ftype_r == amcf_pkg::FTYPE_INTRA) ? amcf_pkg::KEY_FLAG : 5'd0;
    req.position    = movi_offset_r + 32'd4;
    req.length      = len_r;
    req.data        = data_r;
    if (cmd_r == amcf_pkg::CMD_FRAME) begin
      bytes_left_nxt = len_r;
      odd_nxt        = len_r[0];
      if (dur_neg_r || 32'(stream_r) >= MAX_STREAMS) begin
        dropping_nxt = (len_r != 24'd0);
      end else begin
        dropping_nxt    = 1'b0;
        has_result      = 1'b1;
        req.is_frame    = 1'b1;
        movi_offset_nxt = movi_offset_r + 32'(amcf_pkg::HDR_BYTES);
      end
    end else if (bytes_left_r != 24'd0) begin
      bytes_left_nxt = left_dec;
      if (dropping_r) begin
        if (left_dec == 24'd0) begin
          dropping_nxt = 1'b0;
        end
      end else if (left_dec == 24'd0 && odd_r) begin
        has_result      = 1'b1;
        req.pad         = 1'b1;
        odd_nxt         = 1'b0;
        movi_offset_nxt = movi_offset_r + 32'd2;
      end else begin
        has_result      = 1'b1;
        movi_offset_nxt = movi_offset_r + 32'd1;
      end
    end
  end

  assign req_valid = item_valid_r && has_result;
  assign consume   = item_valid_r && (!has_result || req_ready);
  assign in_tready = !item_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r  <= 1'b0;
      movi_offset_r <= 32'd0;
      bytes_left_r  <= 24'd0;
      odd_r         <= 1'b0;
      dropping_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (consume) begin
        movi_offset_r <= movi_offset_nxt;
        bytes_left_r  <= bytes_left_nxt;
        odd_r         <= odd_nxt;
        dropping_r    <= dropping_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r     <= in_cmd;
      stream_r  <= in_stream;
      video_r   <= in_video;
      ftype_r   <= in_ftype;
      len_r     <= in_len;
      dur_neg_r <= in_dur[31];
      data_r    <= in_data;
    end
  end

endmodule

>>> design/amcf_emit.sv
// ----------------------------------------------------------------------------
// AVI movi chunk framer: result formatter
// Turns the held request and the result count into the fields of one result:
// the index entry and the eight header bytes of a chunk, or a payload byte
// and its optional pad.
// ----------------------------------------------------------------------------
module amcf_emit (
  input  amcf_pkg::amcf_req_t  req,
  input  logic [3:0]           cnt,
  output logic                 out_kind,
  output logic [7:0]           out_byte,
  output logic [31:0]          out_tag,
  output logic [4:0]           out_flags,
  output logic [31:0]          out_position,
  output logic [23:0]          out_length,
  output logic                 out_last
);

  logic [7:0] hdr_byte;

  // Header byte for count 1..8: tag bytes, then the little-endian length.
  always_comb begin
    unique case (cnt)
      4'd1:    hdr_byte = req.tag[7:0];
      4'd2:    hdr_byte = req.tag[15:8];
      4'd3:    hdr_byte = req.tag[23:16];
      4'd4:    hdr_byte = req.tag[31:24];
      4'd5:    hdr_byte = req.length[7:0];
      4'd6:    hdr_byte = req.length[15:8];
      4'd7:    hdr_byte = req.length[23:16];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    out_kind     = amcf_pkg::KIND_BYTE;
    out_byte     = 8'd0;
    out_tag      = 32'd0;
    out_flags    = 5'd0;
    out_position = 32'd0;
    out_length   = 24'd0;
    out_last     = 1'b0;
    if (req.is_frame) begin
      if (cnt == 4'd0) begin
        out_kind     = amcf_pkg::KIND_INDEX;
        out_tag      = req.tag;
        out_flags    = req.flags;
        out_position = req.position;
        out_length   = req.length;
      end else begin
        out_byte = hdr_byte;
        out_last = (cnt == amcf_pkg::LAST_HDR_CNT);
      end
    end else begin
      out_byte = (cnt == 4'd0) ? req.data : 8'd0;
      out_last = !req.pad || cnt != 4'd0;
    end
  end

endmodule

>>> design/amcf_seq.sv
// ----------------------------------------------------------------------------
// AVI movi chunk framer: result sequencer
// Holds one request and steps through its results: the index entry and the
// eight header bytes of a chunk, or a payload byte and its optional pad.
// ----------------------------------------------------------------------------
module amcf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  amcf_pkg::amcf_req_t  req,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_kind,
  output logic [7:0]           out_byte,
  output logic [31:0]          out_tag,
  output logic [4:0]           out_flags,
  output logic [31:0]          out_position,
  output logic [23:0]          out_length,
  output logic                 out_last
);

  logic                 busy_r;
  amcf_pkg::amcf_req_t  req_r;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 take;

  assign out_tvalid = busy_r;
  assign take       = busy_r && out_tready;
  assign req_ready  = !busy_r || (take && out_last);

  amcf_emit u_emit (
    .req          (req_r),
    .cnt          (cnt_r),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_tag      (out_tag),
    .out_flags    (out_flags),
    .out_position (out_position),
    .out_length   (out_length),
    .out_last     (out_last)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (req_valid && req_ready) begin
      cnt_nxt = 4'd0;
    end else if (take) begin
      cnt_nxt = out_last ? 4'd0 : cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (req_ready) begin
        busy_r <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= amcf_pkg::LAST_HDR_CNT)
    else $error("result count beyond chunk header");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == 4'd0)
    else $error("result count nonzero while idle");

  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req_r.is_frame |-> cnt_r <= 4'd1)
    else $error("payload request ran past its pad byte");

  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_last |=> out_tvalid)
    else $error("result burst broken before its last result");

endmodule

>>> design/avi_movi_chunk_framer.sv
// ----------------------------------------------------------------------------
// AVI movi chunk framer
// Frames frame descriptors and payload bytes into AVI movi chunks with index
// entries.
// ----------------------------------------------------------------------------
// A frame start request (in_tuser 0) yields nine results: the index entry
// (out_tuser 1) and then the eight chunk header bytes, the last one marked by
// out_tlast. A payload byte request (in_tuser 1) yields one result, or two
// when it closes an odd-length frame and a zero pad byte follows. Dropped
// frames, stray bytes and bytes of dropped frames give no result. The result
// sequencer emits one result per cycle while out_tready is high, so payload
// streams at one byte per cycle, a frame start holds the output for its nine
// results, and a request with no result never waits on the sequencer. Input
// passes the input register, then the sequencer register.
module avi_movi_chunk_framer #(
  parameter int unsigned MAX_STREAMS = amcf_pkg::MAX_STREAMS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [amcf_pkg::IN_TDATA_W-1:0]   in_tdata,   // stream_number, is_video,
                                                        // frame_type, frame_length,
                                                        // frame_duration, data_byte
  input  logic                              in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [amcf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_byte, index_tag,
                                                        // index_flags, index_position,
                                                        // index_length
  output logic                              out_tuser,  // out_kind
  output logic                              out_tlast   // last
);

  logic                 req_valid;
  logic                 req_ready;
  amcf_pkg::amcf_req_t  req;
  logic [7:0]           o_byte;
  logic [31:0]          o_tag;
  logic [4:0]           o_flags;
  logic [31:0]          o_position;
  logic [23:0]          o_length;

  amcf_core #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_stream (in_tdata[6:0]),
    .in_video  (in_tdata[7]),
    .in_ftype  (in_tdata[9:8]),
    .in_len    (in_tdata[33:10]),
    .in_dur    (in_tdata[65:34]),
    .in_data   (in_tdata[73:66]),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  amcf_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_kind     (out_tuser),
    .out_byte     (o_byte),
    .out_tag      (o_tag),
    .out_flags    (o_flags),
    .out_position (o_position),
    .out_length   (o_length),
    .out_last     (out_tlast)
  );

  assign out_tdata = {3'd0, o_length, o_position, o_flags, o_tag, o_byte};

endmodule

>>> tb/sv/movi_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVI movi stream checker
// Watches both stream channels of the chunk framer, predicts the index
// entries and movi bytes for every accepted request and compares each
// accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module movi_stream_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           error_count,
  output int           results_due
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [31:0] tag;
    logic [4:0]  flags;
    logic [31:0] position;
    logic [23:0] length;
    logic        last;
  } movi_result_t;

  logic [31:0]  movi_offset;
  logic [23:0]  bytes_left;
  logic         len_odd;
  logic         dropping;
  movi_result_t chunk_results_q[$];
  int           errs;

  initial begin
    errs = 0;
    error_count = 0;
    results_due = 0;
  end

  // Every byte written into the movi list advances the running offset.
  task automatic emit_byte(input logic [7:0] b, input logic fin);
    movi_result_t r;
    r = '0;
    r.kind = amcf_pkg::KIND_BYTE;
    r.data = b;
    r.last = fin;
    chunk_results_q.push_back(r);
    movi_offset = movi_offset + 32'd1;
  endtask

  task automatic predict_chunk(input logic cmd, input logic [79:0] d);
    logic [6:0]   stream;
    logic         video;
    logic [1:0]   ftype;
    logic [23:0]  len;
    logic [31:0]  dur;
    logic [7:0]   data;
    logic [31:0]  tag;
    logic [7:0]   hdr [8];
    movi_result_t r;
    stream = d[6:0];
    video  = d[7];
    ftype  = d[9:8];
    len    = d[33:10];
    dur    = d[65:34];
    data   = d[73:66];
    if (cmd == amcf_pkg::CMD_FRAME) begin
      bytes_left = len;
      len_odd = len[0];
      if (dur[31] || stream >= amcf_pkg::MAX_STREAMS) begin
        dropping = (len != 24'd0);
      end else begin
        dropping = 1'b0;
        tag = {video ? amcf_pkg::CHR_C : amcf_pkg::CHR_B,
               video ? amcf_pkg::CHR_D : amcf_pkg::CHR_W,
               amcf_pkg::CHR_0 + 8'(stream % 7'd10),
               amcf_pkg::CHR_0 + 8'(stream / 7'd10)};
        r = '0;
        r.kind = amcf_pkg::KIND_INDEX;
        r.tag = tag;
        r.flags = (ftype == amcf_pkg::FTYPE_UNKNOWN || ftype == amcf_pkg::FTYPE_INTRA) ?
                  amcf_pkg::KEY_FLAG : 5'd0;
        r.position = movi_offset + 32'd4;
        r.length = len;
        chunk_results_q.push_back(r);
        for (int i = 0; i < 4; i++) hdr[i] = tag[8*i +: 8];
        for (int i = 0; i < 3; i++) hdr[4+i] = len[8*i +: 8];
        hdr[7] = 8'h00;
        for (int i = 0; i < 8; i++) emit_byte(hdr[i], i == 7);
      end
    end else if (bytes_left != 24'd0) begin
      bytes_left = bytes_left - 24'd1;
      if (dropping) begin
        if (bytes_left == 24'd0) dropping = 1'b0;
      end else if (bytes_left == 24'd0 && len_odd) begin
        // The closing byte of an odd-length frame is followed by a zero pad.
        emit_byte(data, 1'b0);
        emit_byte(8'h00, 1'b1);
        len_odd = 1'b0;
      end else begin
        emit_byte(data, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    movi_result_t got;
    movi_result_t want;
    if (!rst_n) begin
      movi_offset = '0;
      bytes_left = '0;
      len_odd = 1'b0;
      dropping = 1'b0;
      chunk_results_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_chunk(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind     = out_tuser;
        got.data     = out_tdata[7:0];
        got.tag      = out_tdata[39:8];
        got.flags    = out_tdata[44:40];
        got.position = out_tdata[76:45];
        got.length   = out_tdata[100:77];
        got.last     = out_tlast;
        if (chunk_results_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result kind %0d byte %02h tag %08h last %0d",
                     $time, got.kind, got.data, got.tag, got.last);
        end else begin
          want = chunk_results_q.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  exp kind %0d byte %02h tag %08h flags %02h pos %08h len %06h last %0d",
                       want.kind, want.data, want.tag, want.flags,
                       want.position, want.length, want.last);
              $display("  act kind %0d byte %02h tag %08h flags %02h pos %08h len %06h last %0d",
                       got.kind, got.data, got.tag, got.flags,
                       got.position, got.length, got.last);
            end
          end
        end
      end
    end
    error_count <= errs;
    results_due <= chunk_results_q.size();
  end

endmodule

>>> tb/sv/tb_avi_movi_chunk_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVI movi chunk framer testbench
// Drives frame descriptors and payload bytes with random gaps and result
// stalls, including one long output hold-off; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_avi_movi_chunk_framer;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  int           error_count;
  int           results_due;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_off_req = 1'b0;
  int items_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  avi_movi_chunk_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  movi_stream_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .error_count (error_count),
    .results_due (results_due)
  );

  function automatic logic [79:0] frame_word(input logic [6:0] stream, input logic video,
                                             input logic [1:0] ftype, input logic [23:0] len,
                                             input logic [31:0] dur);
    return {6'b0, 8'($urandom()), dur, len, ftype, video, stream};
  endfunction

  // Descriptor fields are don't-care on a payload request, so they get noise.
  function automatic logic [79:0] payload_word(input logic [7:0] b);
    return {6'b0, b, 32'($urandom()), 24'($urandom()), 10'($urandom())};
  endfunction

  task automatic send_request(input logic cmd, input logic [79:0] d);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++)
      send_request(amcf_pkg::CMD_BYTE, payload_word(8'($urandom())));
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int w;
    forever begin
      if ($urandom_range(0, 49) == 0) recv_idle = !recv_idle;
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      w = recv_idle ? $urandom_range(0, 4) : 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          roll;
    int          nbytes;
    bit          hold_done;
    logic [6:0]  stream;
    logic [23:0] len;
    logic [31:0] dur;
    hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Odd-length key frame on stream 0; the last byte pulls in a pad byte.
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd0, 1'b1, 2'd0, 24'd3, 32'd0));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h00));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'hFF));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'hA5));
    // Empty audio frame on the highest stream, largest positive duration.
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd99, 1'b0, 2'd1, 24'd0, 32'h7FFF_FFFF));
    // A byte with no frame open is ignored.
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h5A));
    // Negative duration drops the frame and its bytes.
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd42, 1'b1, 2'd2, 24'd2, 32'hFFFF_FFFF));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h11));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h22));
    // Stream number past the limit is dropped the same way.
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd100, 1'b0, 2'd3, 24'd1, 32'd5));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h33));
    // Huge dropped frame, abandoned by the next descriptor.
    send_request(amcf_pkg::CMD_FRAME,
                 frame_word(7'd127, 1'b0, 2'd3, 24'hFF_FFFF, 32'h8000_0000));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h44));
    // Huge live frame cut short by a new frame start.
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd12, 1'b1, 2'd1, 24'hFF_FFFF, 32'd1));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h0F));
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd7, 1'b1, 2'd3, 24'd4, 32'd1));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'hF0));
    send_request(amcf_pkg::CMD_FRAME, frame_word(7'd55, 1'b0, 2'd2, 24'd1, 32'd2));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h96));
    send_request(amcf_pkg::CMD_BYTE, payload_word(8'h69));

    while (items_sent < 300) begin
      if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
      if (!hold_done && items_sent >= 120) begin
        // Keep offering a long frame while the output is held off.
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        send_idle = 1'b0;
        send_request(amcf_pkg::CMD_FRAME, frame_word(7'd3, 1'b1, 2'd0, 24'd60, 32'd10));
        send_payload(60);
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        stream = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(100, 127))
                                              : 7'($urandom_range(0, 99));
        dur = ($urandom_range(0, 9) == 0) ? ($urandom() | 32'h8000_0000)
                                          : ($urandom() & 32'h7FFF_FFFF);
        roll = $urandom_range(0, 99);
        if (roll < 70) len = 24'($urandom_range(0, 12));
        else if (roll < 95) len = 24'($urandom_range(13, 40));
        else len = 24'($urandom()) | 24'h80_0000;
        nbytes = (len > 24'd40) ? $urandom_range(0, 8) : int'(len);
        if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
        send_request(amcf_pkg::CMD_FRAME,
                     frame_word(stream, 1'($urandom()), 2'($urandom()), len, dur));
        send_payload(nbytes);
        if (nbytes == int'(len) && $urandom_range(0, 9) == 0)
          send_payload($urandom_range(1, 3));
      end else if (roll < 92) begin
        len = ($urandom_range(0, 1) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 20));
        send_request(amcf_pkg::CMD_FRAME,
                     frame_word(7'($urandom()), 1'($urandom()),
                                2'($urandom()), len, 32'($urandom())));
        send_payload($urandom_range(0, 5));
      end else begin
        send_payload($urandom_range(1, 3));
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
design/amcf_pkg.sv
design/amcf_core.sv
design/amcf_emit.sv
design/amcf_seq.sv
design/avi_movi_chunk_framer.sv
tb/sv/movi_stream_checker.sv
tb/sv/tb_avi_movi_chunk_framer.sv
